@@ src/pooled_sorted_linked_list_macros.svh @@
// Assertion macros for the pooled sorted linked list.
// Expects clk and rst in scope where used.
`ifndef POOLED_SORTED_LINKED_LIST_MACROS_SVH
`define POOLED_SORTED_LINKED_LIST_MACROS_SVH

// Condition holds at every edge out of reset.
`define PSLL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PSLL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/psll_pkg.sv @@
// Shared constants, request codes and controller/datapath interface types
// for the pooled sorted linked list. No dependencies.
package psll_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int KEY_BITS         = 32;
  localparam int KIND_BITS        = 3;
  localparam int POS_BITS         = 6;
  localparam int SLOT_OUT_BITS    = 6;
  localparam int COUNT_OUT_BITS   = 7;

  localparam logic [KIND_BITS-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_REMKEY = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_REMPOS = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_SEARCH = 3'd4;

  typedef struct packed {
    logic clear;
    logic load_req;
    logic start;
    logic step;
    logic free_rd;
    logic ins_a;
    logic ins_b;
    logic rem_a;
    logic rem_b;
    logic mark_found;
    logic mark_fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 free_null;
    logic                 prev_null;
    logic                 walk_cont;
    logic                 found;
    logic                 clear_done;
  } stat_t;

endpackage

@@ src/pooled_sorted_linked_list.sv @@
// Pooled sorted linked list: one result word per request word.
// Push takes no walk, and an unused kind fails at once; walking requests
// (search, ordered insert, removal) follow the list one link per cycle
// through the registered link store read. The next word is accepted only
// once the result is loaded. After reset the free chain is rebuilt, with
// no word accepted meanwhile.
module pooled_sorted_linked_list import psll_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KIND_BITS-1:0]       kind,
  input  logic signed [KEY_BITS-1:0] key,
  input  logic [PAYLOAD_BITS-1:0]    payload,
  input  logic [POS_BITS-1:0]        position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ok,
  output logic [SLOT_OUT_BITS-1:0]   slot,
  output logic [COUNT_OUT_BITS-1:0]  count
);

  cmd_t  cmd;
  stat_t stat;

  psll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psll_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .kind     (kind),
    .key      (key),
    .payload  (payload),
    .position (position),
    .ok       (ok),
    .slot     (slot),
    .count    (count)
  );

endmodule

@@ src/psll_datapath.sv @@
// Datapath: link, key and payload stores, list pointers, walk registers
// and result registers. Depends on psll_pkg and the assertion macros.
`include "pooled_sorted_linked_list_macros.svh"

module psll_datapath import psll_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic [KIND_BITS-1:0]       kind,
  input  logic signed [KEY_BITS-1:0] key,
  input  logic [PAYLOAD_BITS-1:0]    payload,
  input  logic [POS_BITS-1:0]        position,
  output logic                       ok,
  output logic [SLOT_OUT_BITS-1:0]   slot,
  output logic [COUNT_OUT_BITS-1:0]  count
);

  localparam int SB = $clog2(CAPACITY);
  localparam int PB = SB + 1;
  localparam int CB = $clog2(CAPACITY + 1);
  localparam logic [PB-1:0] NIL = PB'(CAPACITY);

  logic [PB-1:0] next_link [CAPACITY];
  logic signed [KEY_BITS-1:0] key_store [CAPACITY];
  logic [PAYLOAD_BITS-1:0] payload_store [CAPACITY];

  logic [KIND_BITS-1:0]       req_kind;
  logic signed [KEY_BITS-1:0] req_key;
  logic [PAYLOAD_BITS-1:0]    req_pay;
  logic [POS_BITS-1:0]        req_pos;

  logic [PB-1:0] head, free_head, cur, prev, sel;
  logic [CB-1:0] steps, cnt;
  logic [SB-1:0] clr_idx;
  logic          res_ok;
  logic [PB-1:0] link_q;
  logic signed [KEY_BITS-1:0] key_q;

  logic          rd_en, wr_en;
  logic [SB-1:0] rd_addr, wr_addr;
  logic [PB-1:0] wr_data;
  logic          cur_null, head_null, link_null, lt_cap;

  assign cur_null  = cur >= NIL;
  assign head_null = head >= NIL;
  assign link_null = link_q >= NIL;
  assign lt_cap    = steps < CB'(CAPACITY);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head[SB-1:0];
    if (cmd.start) begin
      rd_en = !head_null;
    end else if (cmd.step) begin
      rd_en   = !link_null;
      rd_addr = link_q[SB-1:0];
    end else if (cmd.free_rd) begin
      rd_en   = 1'b1;
      rd_addr = free_head[SB-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = sel[SB-1:0];
    wr_data = cur;
    priority if (cmd.clear) begin
      wr_addr = clr_idx;
      wr_data = PB'(clr_idx) + PB'(1);
    end else if (cmd.ins_a) begin
      wr_data = cur;
    end else if (cmd.ins_b) begin
      wr_addr = prev[SB-1:0];
      wr_data = sel;
    end else if (cmd.rem_a) begin
      wr_data = free_head;
    end else if (cmd.rem_b) begin
      wr_addr = prev[SB-1:0];
      wr_data = link_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_q <= next_link[rd_addr];
      key_q  <= key_store[rd_addr];
    end
    if (wr_en) begin
      next_link[wr_addr] <= wr_data;
    end
    if (cmd.ins_a) begin
      key_store[sel[SB-1:0]]     <= req_key;
      payload_store[sel[SB-1:0]] <= req_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind <= kind;
      req_key  <= key;
      req_pay  <= payload;
      req_pos  <= position;
    end
    if (cmd.start) begin
      cur   <= head;
      prev  <= NIL;
      steps <= '0;
    end else if (cmd.step) begin
      prev  <= cur;
      cur   <= link_q;
      steps <= steps + CB'(1);
    end
    if (cmd.out_load) begin
      ok    <= res_ok;
      slot  <= SLOT_OUT_BITS'(sel);
      count <= COUNT_OUT_BITS'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      free_head <= '0;
      cnt       <= '0;
      clr_idx   <= '0;
      res_ok    <= 1'b0;
      sel       <= '0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + SB'(1);
      if (cmd.mark_fail) begin
        res_ok <= 1'b0;
        sel    <= '0;
      end else if (cmd.mark_found) begin
        res_ok <= 1'b1;
        sel    <= cur;
      end else if (cmd.free_rd) begin
        res_ok <= 1'b1;
        sel    <= free_head;
      end
      if (cmd.ins_a) begin
        // take the head of the free chain
        free_head <= link_q;
        cnt       <= cnt + CB'(1);
        if (prev >= NIL) head <= sel;
      end
      if (cmd.rem_a) begin
        // return the slot to the free chain, bypass it in the list
        free_head <= sel;
        if (cnt != '0) cnt <= cnt - CB'(1);
        if (prev >= NIL) head <= link_q;
      end
    end
  end

  always_comb begin
    stat.kind       = req_kind;
    stat.free_null  = free_head >= NIL;
    stat.prev_null  = prev >= NIL;
    stat.clear_done = clr_idx == SB'(CAPACITY - 1);
    unique case (req_kind)
      KIND_INSERT: stat.walk_cont = !cur_null && lt_cap && (key_q <= req_key);
      KIND_REMKEY,
      KIND_SEARCH: stat.walk_cont = !cur_null && lt_cap && (key_q != req_key);
      KIND_REMPOS: stat.walk_cont = !cur_null && (32'(steps) < 32'(req_pos));
      default:     stat.walk_cont = 1'b0;
    endcase
    if (req_kind == KIND_REMPOS) stat.found = !cur_null;
    else                         stat.found = !cur_null && lt_cap;
  end

  `PSLL_ASSERT_ALWAYS(a_cnt_bound, cnt <= CB'(CAPACITY), "entry count beyond capacity")
  `PSLL_ASSERT_IMPLIES(a_fail_slot, !res_ok, sel == '0, "failed result carries a slot")
  `PSLL_ASSERT_IMPLIES(a_ins_free, cmd.ins_a, free_head < NIL, "insert with empty free chain")

endmodule

@@ src/psll_ctrl.sv @@
// Controller: sequences clearing, list walks and link write-back, and
// owns the handshakes. Depends on psll_pkg.
module psll_ctrl import psll_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_WALK, S_FREE, S_WRA, S_WRB, S_DONE
  } state_t;

  state_t state, state_next;
  logic   is_ins;

  assign in_ready = state == S_IDLE;
  assign is_ins   = stat.kind == KIND_PUSH || stat.kind == KIND_INSERT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load_req = in_valid;
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        unique case (stat.kind)
          KIND_PUSH, KIND_INSERT: begin
            if (stat.free_null) begin
              cmd.mark_fail = 1'b1;
              state_next    = S_DONE;
            end else begin
              state_next = (stat.kind == KIND_PUSH) ? S_FREE : S_WALK;
            end
          end
          KIND_REMKEY, KIND_REMPOS, KIND_SEARCH: state_next = S_WALK;
          default: begin
            cmd.mark_fail = 1'b1;
            state_next    = S_DONE;
          end
        endcase
      end
      S_WALK: begin
        if (stat.walk_cont) begin
          cmd.step = 1'b1;
        end else if (stat.kind == KIND_INSERT) begin
          state_next = S_FREE;
        end else if (stat.found) begin
          cmd.mark_found = 1'b1;
          state_next     = (stat.kind == KIND_SEARCH) ? S_DONE : S_WRA;
        end else begin
          cmd.mark_fail = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_FREE: begin
        cmd.free_rd = 1'b1;
        state_next  = S_WRA;
      end
      S_WRA: begin
        cmd.ins_a  = is_ins;
        cmd.rem_a  = !is_ins;
        state_next = stat.prev_null ? S_DONE : S_WRB;
      end
      S_WRB: begin
        cmd.ins_b  = is_ins;
        cmd.rem_b  = !is_ins;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        cmd.out_load = !out_valid || out_ready;
        if (cmd.out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
